// ===== design/lsb_pkg.sv =====
package lsb_pkg;

	localparam int LED_SLOTS = 24;
	localparam int ENTRIES = 2 * LED_SLOTS;
	localparam int AW = $clog2(ENTRIES);
	localparam int SW = $clog2(LED_SLOTS);

	localparam logic [1:0] KIND_SET = 2'd0;
	localparam logic [1:0] KIND_BAD_INDEX = 2'd1;
	localparam logic [1:0] KIND_FLUSH_DATA = 2'd2;
	localparam logic [1:0] KIND_FLUSH_EMPTY = 2'd3;

	localparam logic MODE_SET = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef struct packed {
		logic rd_en;
		logic [AW-1:0] rd_addr;
		logic wr_en;
		logic [AW-1:0] wr_addr;
		logic [23:0] wr_data;
	} mem_req_t;

	// logical led number to slot: (i%4)*6 + i/4
	function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] idx);
		logic [SW-1:0] lo;
		logic [SW-1:0] hi;
		begin
			lo = SW'(idx[1:0]);
			hi = SW'(idx[SW-1:2]);
			slot_of = SW'(lo * SW'(6) + hi);
		end
	endfunction

	function automatic logic [AW-1:0] entry_of(input logic bank, input logic [SW-1:0] slot);
		entry_of = AW'(slot) + (bank ? AW'(LED_SLOTS) : AW'(0));
	endfunction

	function automatic logic [6:0] reg_addr_of(input logic [SW-1:0] slot);
		reg_addr_of = 7'd1 + 7'(slot) * 7'd3;
	endfunction

endpackage

// ===== design/lsb_store.sv =====
module lsb_store (
	input  logic clk,
	input  logic arst_n,
	input  lsb_pkg::mem_req_t req,
	output logic [23:0] rd_data
);

	logic [23:0] mem_q [lsb_pkg::ENTRIES];
	logic [lsb_pkg::ENTRIES-1:0] valid_q;
	logic [23:0] rd_raw_q;
	logic rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_raw_q <= mem_q[req.rd_addr];
		end
	end

	// never-written entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_raw_q : 24'd0;

endmodule

// ===== design/led_shadow_buffer_dirty_flush_unit.sv =====
// Shadow store for 24 RGB LED slots in two banks (color, scale), each with
// a dirty window of slots that changed since the last flush.
// Input channel s_*: one item is a set (write one LED's bytes) or a flush
// of one bank. Output channel m_*: result items, m_tlast on the final one.
// A set item does a memory read, then a compare and write back, and
// gives one result. A bad index or a flush with nothing dirty gives one
// result. A flush streams its dirty slots out, one slot per cycle while
// the output register can take results, through the one read port of
// the pixel memory, and no input is taken until the last slot is out.
// Results sit in one output register; the next item is accepted while a
// result still waits there, and the block stalls at its result step while
// m_tready stays low, without losing or repeating anything.
// Reset clears all pixel bytes (per-entry valid bits, no clearing pass),
// all dirty windows and the output register; the block is ready at once.
module led_shadow_buffer_dirty_flush_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [31:0] s_tdata, // led number, red, green, blue
	input  logic [1:0] s_tuser,  // mode, buffer_select
	output logic m_tvalid,
	input  logic m_tready,
	output logic [31:0] m_tdata, // register_address, blue_byte, green_byte, red_byte
	output logic [3:0] m_tuser,  // kind (2), bank, changed
	output logic m_tlast
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SET = 2'd1;
	localparam logic [1:0] ST_ONE = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	localparam int SW = lsb_pkg::SW;

	logic [1:0] state_q;
	logic bank_q;
	logic [SW-1:0] slot_q;
	logic [23:0] px_q;
	logic [1:0] one_kind_q;

	logic [SW-1:0] dlo_q [2];
	logic [SW-1:0] dhi_q [2];
	logic [1:0] dval_q;

	logic [SW-1:0] cur_q;
	logic [SW-1:0] hi_q;
	logic more_q;
	logic valid_s1;
	logic [SW-1:0] slot_s1;
	logic last_s1;

	logic out_valid_q;
	logic [1:0] out_kind_q;
	logic out_bank_q;
	logic [6:0] out_addr_q;
	logic [23:0] out_px_q;
	logic out_changed_q;
	logic out_last_q;

	lsb_pkg::mem_req_t req;
	logic [23:0] rd_data;

	logic accept;
	logic in_mode;
	logic in_bank;
	logic [7:0] in_idx;
	logic idx_ok;
	logic [SW-1:0] in_slot;
	logic out_free;
	logic out_load;
	logic adv;
	logic changed;

	assign in_mode = s_tuser[0];
	assign in_bank = s_tuser[1];
	assign in_idx = s_tdata[7:0];
	assign idx_ok = (in_idx[7:SW] == '0) && (in_idx[SW-1:0] < SW'(lsb_pkg::LED_SLOTS));
	assign in_slot = lsb_pkg::slot_of(in_idx[SW-1:0]);

	assign s_tready = (state_q == ST_IDLE);
	assign accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign adv = (state_q == ST_FLUSH) && (!valid_s1 || out_free);
	assign out_load = ((state_q == ST_SET || state_q == ST_ONE) && out_free) || (adv && valid_s1);
	assign changed = (rd_data != px_q);

	always_comb begin
		req = '0;
		if (accept && in_mode == lsb_pkg::MODE_SET && idx_ok) begin
			req.rd_en = 1'b1;
			req.rd_addr = lsb_pkg::entry_of(in_bank, in_slot);
		end else if (adv && more_q) begin
			req.rd_en = 1'b1;
			req.rd_addr = lsb_pkg::entry_of(bank_q, cur_q);
		end
		if (state_q == ST_SET && out_free) begin
			req.wr_en = 1'b1;
			req.wr_addr = lsb_pkg::entry_of(bank_q, slot_q);
			req.wr_data = px_q;
		end
	end

	lsb_store u_store (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rd_data(rd_data)
	);

	// item capture, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			bank_q <= in_bank;
			slot_q <= in_slot;
			px_q <= {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
		end
		if (adv && more_q) begin
			slot_s1 <= cur_q;
			last_s1 <= (cur_q == hi_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			one_kind_q <= lsb_pkg::KIND_SET;
			dlo_q[0] <= '0;
			dlo_q[1] <= '0;
			dhi_q[0] <= '0;
			dhi_q[1] <= '0;
			dval_q <= '0;
			cur_q <= '0;
			hi_q <= '0;
			more_q <= 1'b0;
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			out_kind_q <= lsb_pkg::KIND_SET;
			out_bank_q <= 1'b0;
			out_addr_q <= '0;
			out_px_q <= '0;
			out_changed_q <= 1'b0;
			out_last_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_mode == lsb_pkg::MODE_SET) begin
							if (idx_ok) begin
								state_q <= ST_SET;
							end else begin
								one_kind_q <= lsb_pkg::KIND_BAD_INDEX;
								state_q <= ST_ONE;
							end
						end else if (!dval_q[in_bank]) begin
							one_kind_q <= lsb_pkg::KIND_FLUSH_EMPTY;
							state_q <= ST_ONE;
						end else begin
							// take the window and clear it up front
							cur_q <= dlo_q[in_bank];
							hi_q <= dhi_q[in_bank];
							more_q <= 1'b1;
							dval_q[in_bank] <= 1'b0;
							dlo_q[in_bank] <= '0;
							dhi_q[in_bank] <= '0;
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_SET: begin
					if (out_free) begin
						if (changed) begin
							dval_q[bank_q] <= 1'b1;
							if (!dval_q[bank_q]) begin
								dlo_q[bank_q] <= slot_q;
								dhi_q[bank_q] <= slot_q;
							end else begin
								if (slot_q < dlo_q[bank_q]) begin
									dlo_q[bank_q] <= slot_q;
								end
								if (slot_q > dhi_q[bank_q]) begin
									dhi_q[bank_q] <= slot_q;
								end
							end
						end
						out_kind_q <= lsb_pkg::KIND_SET;
						out_bank_q <= bank_q;
						out_addr_q <= lsb_pkg::reg_addr_of(slot_q);
						out_px_q <= px_q;
						out_changed_q <= changed;
						out_last_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_ONE: begin
					if (out_free) begin
						out_kind_q <= one_kind_q;
						out_bank_q <= bank_q;
						out_addr_q <= '0;
						out_px_q <= '0;
						out_changed_q <= 1'b0;
						out_last_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (adv) begin
						if (valid_s1) begin
							out_kind_q <= lsb_pkg::KIND_FLUSH_DATA;
							out_bank_q <= bank_q;
							out_addr_q <= lsb_pkg::reg_addr_of(slot_s1);
							out_px_q <= rd_data;
							out_changed_q <= 1'b0;
							out_last_q <= last_s1;
						end
						valid_s1 <= more_q;
						if (more_q) begin
							if (cur_q == hi_q) begin
								more_q <= 1'b0;
							end else begin
								cur_q <= cur_q + SW'(1);
							end
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, out_px_q[23:16], out_px_q[15:8], out_px_q[7:0], out_addr_q};
	assign m_tuser = {out_changed_q, out_bank_q, out_kind_q};
	assign m_tlast = out_last_q;

endmodule

// ===== dv/led_shadow_buffer_dirty_flush_unit_test.sv =====
`timescale 1ns / 1ps
module led_shadow_buffer_dirty_flush_unit_test;

	localparam int RANDOM_ITEMS = 500;
	localparam int CALM_ITEMS = 80;
	localparam int HOLD_AT_ITEM = 100;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		logic mode;
		logic bank;
		logic [7:0] led_num;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} led_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic bank;
		logic [6:0] reg_addr;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic changed;
		logic last;
	} reg_write_t;

	typedef struct packed {
		led_cmd_t cmd;
		logic typed;
		reg_write_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [3:0] m_tuser;
	logic m_tlast;

	led_shadow_buffer_dirty_flush_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #5 clk = ~clk;

	// shadow copy of the block's stores
	logic [23:0] shadow_px [0:2*lsb_pkg::LED_SLOTS-1];
	logic [4:0] win_lo [0:1];
	logic [4:0] win_hi [0:1];
	logic win_open [0:1];

	reg_write_t expected_writes[$];
	dir_row_t directed_rows[$];

	int fails = 0;
	int items_sent = 0;
	int n_set = 0;
	int n_unchanged = 0;
	int n_bad = 0;
	int n_flush_slots = 0;
	int n_flush_empty = 0;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	function automatic string describe(input reg_write_t w);
		return $sformatf("kind=%0d bank=%0d addr=%0d b=%02h g=%02h r=%02h chg=%0d last=%0d",
			w.kind, w.bank, w.reg_addr, w.blue, w.green, w.red, w.changed, w.last);
	endfunction

	task automatic shadow_apply(input led_cmd_t c);
		int slot;
		int entry;
		int lo;
		int hi;
		logic [23:0] px;
		reg_write_t r;
		r = '0;
		r.bank = c.bank;
		r.last = 1'b1;
		if (c.mode == lsb_pkg::MODE_SET) begin
			if (c.led_num >= lsb_pkg::LED_SLOTS) begin
				r.kind = lsb_pkg::KIND_BAD_INDEX;
			end else begin
				slot = (c.led_num % 4) * 6 + c.led_num / 4;
				entry = c.bank * lsb_pkg::LED_SLOTS + slot;
				px = {c.red, c.green, c.blue};
				r.kind = lsb_pkg::KIND_SET;
				r.reg_addr = 7'(1 + 3 * slot);
				{r.red, r.green, r.blue} = px;
				r.changed = (px != shadow_px[entry]);
				shadow_px[entry] = px;
				if (r.changed) begin
					if (!win_open[c.bank]) begin
						win_open[c.bank] = 1'b1;
						win_lo[c.bank] = 5'(slot);
						win_hi[c.bank] = 5'(slot);
					end else begin
						if (slot < win_lo[c.bank])
							win_lo[c.bank] = 5'(slot);
						if (slot > win_hi[c.bank])
							win_hi[c.bank] = 5'(slot);
					end
				end
			end
			expected_writes.push_back(r);
		end else if (!win_open[c.bank]) begin
			r.kind = lsb_pkg::KIND_FLUSH_EMPTY;
			expected_writes.push_back(r);
		end else begin
			lo = win_lo[c.bank];
			hi = win_hi[c.bank];
			if (hi >= lsb_pkg::LED_SLOTS)
				hi = lsb_pkg::LED_SLOTS - 1;
			if (lo > hi)
				lo = hi;
			for (int s = lo; s <= hi; s++) begin
				r.kind = lsb_pkg::KIND_FLUSH_DATA;
				r.reg_addr = 7'(1 + 3 * s);
				{r.red, r.green, r.blue} = shadow_px[c.bank * lsb_pkg::LED_SLOTS + s];
				r.last = (s == hi);
				expected_writes.push_back(r);
			end
			win_open[c.bank] = 1'b0;
			win_lo[c.bank] = '0;
			win_hi[c.bank] = '0;
		end
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 3))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic led_cmd_t random_cmd();
		led_cmd_t c;
		int roll;
		int slot;
		c.bank = 1'($urandom);
		c.mode = lsb_pkg::MODE_SET;
		c.led_num = 8'($urandom_range(0, lsb_pkg::LED_SLOTS - 1));
		c.red = pick_byte();
		c.green = pick_byte();
		c.blue = pick_byte();
		roll = $urandom_range(0, 99);
		if (roll < 18) begin
			c.mode = lsb_pkg::MODE_FLUSH;
			{c.led_num, c.red, c.green, c.blue} = $urandom;
		end else if (roll < 26) begin
			c.led_num = 8'($urandom_range(lsb_pkg::LED_SLOTS, 255));
		end else if (roll < 40) begin
			// rewrite what is already stored so nothing changes
			slot = (c.led_num % 4) * 6 + c.led_num / 4;
			{c.red, c.green, c.blue} = shadow_px[c.bank * lsb_pkg::LED_SLOTS + slot];
		end
		return c;
	endfunction

	function automatic dir_row_t predicted(input led_cmd_t c);
		return '{c, 1'b0, '0};
	endfunction

	function automatic dir_row_t checked(input led_cmd_t c, input reg_write_t w);
		return '{c, 1'b1, w};
	endfunction

	task automatic send_cmd(input dir_row_t d);
		int n0;
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			s_tuser <= 2'($urandom);
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {d.cmd.blue, d.cmd.green, d.cmd.red, d.cmd.led_num};
		s_tuser <= {d.cmd.bank, d.cmd.mode};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n0 = expected_writes.size();
		shadow_apply(d.cmd);
		if (d.typed) begin
			while (expected_writes.size() > n0)
				void'(expected_writes.pop_back());
			expected_writes.push_back(d.want);
		end
		items_sent++;
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			// long hold-off so the output register fills and input stalls
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 10);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		reg_write_t got;
		reg_write_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.kind = m_tuser[1:0];
			got.bank = m_tuser[2];
			got.changed = m_tuser[3];
			got.reg_addr = m_tdata[6:0];
			got.blue = m_tdata[14:7];
			got.green = m_tdata[22:15];
			got.red = m_tdata[30:23];
			got.last = m_tlast;
			if (expected_writes.size() == 0) begin
				fails++;
				if (fails <= REPORT_MAX)
					$display("unexpected item: %s", describe(got));
			end else begin
				want = expected_writes.pop_front();
				if (got !== want) begin
					fails++;
					if (fails <= REPORT_MAX)
						$display("mismatch: expected %s, got %s", describe(want),
							describe(got));
				end
			end
			case (got.kind)
				lsb_pkg::KIND_SET: begin
					n_set++;
					if (!got.changed)
						n_unchanged++;
				end
				lsb_pkg::KIND_BAD_INDEX: n_bad++;
				lsb_pkg::KIND_FLUSH_DATA: n_flush_slots++;
				default: n_flush_empty++;
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < 2 * lsb_pkg::LED_SLOTS; i++)
			shadow_px[i] = '0;
		for (int b = 0; b < 2; b++) begin
			win_lo[b] = '0;
			win_hi[b] = '0;
			win_open[b] = 1'b0;
		end

		// after reset nothing is dirty, bad indexes give zeroed results
		directed_rows.push_back(checked(
			'{lsb_pkg::MODE_FLUSH, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
			'{lsb_pkg::KIND_FLUSH_EMPTY, 1'b0, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1}));
		directed_rows.push_back(checked(
			'{lsb_pkg::MODE_FLUSH, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
			'{lsb_pkg::KIND_FLUSH_EMPTY, 1'b1, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1}));
		directed_rows.push_back(checked(
			'{lsb_pkg::MODE_SET, 1'b0, 8'd24, 8'hFF, 8'hFF, 8'hFF},
			'{lsb_pkg::KIND_BAD_INDEX, 1'b0, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1}));
		directed_rows.push_back(checked(
			'{lsb_pkg::MODE_SET, 1'b1, 8'd255, 8'hAA, 8'h55, 8'hAA},
			'{lsb_pkg::KIND_BAD_INDEX, 1'b1, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1}));
		// writing zeros over cleared bytes leaves the window closed
		directed_rows.push_back(checked(
			'{lsb_pkg::MODE_SET, 1'b0, 8'd0, 8'h00, 8'h00, 8'h00},
			'{lsb_pkg::KIND_SET, 1'b0, 7'd1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1}));
		directed_rows.push_back(checked(
			'{lsb_pkg::MODE_FLUSH, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
			'{lsb_pkg::KIND_FLUSH_EMPTY, 1'b0, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1}));
		directed_rows.push_back(checked(
			'{lsb_pkg::MODE_SET, 1'b0, 8'd0, 8'hFF, 8'hFF, 8'hFF},
			'{lsb_pkg::KIND_SET, 1'b0, 7'd1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}));
		// full window 0..23, every slot streamed
		directed_rows.push_back(predicted('{lsb_pkg::MODE_SET, 1'b0, 8'd23, 8'h12, 8'h34, 8'h56}));
		directed_rows.push_back(predicted('{lsb_pkg::MODE_SET, 1'b0, 8'd3, 8'h80, 8'h01, 8'hFE}));
		directed_rows.push_back(predicted('{lsb_pkg::MODE_FLUSH, 1'b0, 8'd7, 8'd1, 8'd2, 8'd3}));
		directed_rows.push_back(checked(
			'{lsb_pkg::MODE_FLUSH, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0},
			'{lsb_pkg::KIND_FLUSH_EMPTY, 1'b0, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1}));
		directed_rows.push_back(predicted('{lsb_pkg::MODE_SET, 1'b1, 8'd5, 8'hAA, 8'h55, 8'h0F}));
		directed_rows.push_back(predicted('{lsb_pkg::MODE_SET, 1'b1, 8'd6, 8'hF0, 8'h0F, 8'h81}));
		directed_rows.push_back(predicted('{lsb_pkg::MODE_SET, 1'b1, 8'd6, 8'hF0, 8'h0F, 8'h81}));
		directed_rows.push_back(predicted('{lsb_pkg::MODE_FLUSH, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0}));
		directed_rows.push_back(predicted('{lsb_pkg::MODE_SET, 1'b1, 8'd4, 8'hFF, 8'h00, 8'hFF}));
		directed_rows.push_back(predicted('{lsb_pkg::MODE_SET, 1'b0, 8'd12, 8'h01, 8'h02, 8'h03}));
		// single-slot windows, one per bank
		directed_rows.push_back(predicted('{lsb_pkg::MODE_FLUSH, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF}));
		directed_rows.push_back(predicted('{lsb_pkg::MODE_FLUSH, 1'b0, 8'h5A, 8'hA5, 8'h5A, 8'hA5}));
		directed_rows.push_back(checked(
			'{lsb_pkg::MODE_SET, 1'b0, 8'd128, 8'h7F, 8'h80, 8'h01},
			'{lsb_pkg::KIND_BAD_INDEX, 1'b0, 7'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1}));
		directed_rows.push_back(predicted('{lsb_pkg::MODE_SET, 1'b0, 8'd23, 8'h00, 8'h00, 8'h00}));
		directed_rows.push_back(predicted('{lsb_pkg::MODE_SET, 1'b0, 8'd20, 8'h55, 8'hAA, 8'h55}));
		directed_rows.push_back(predicted('{lsb_pkg::MODE_FLUSH, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0}));
		directed_rows.push_back(predicted('{lsb_pkg::MODE_SET, 1'b1, 8'd7, 8'h7F, 8'hC3, 8'h3C}));

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_cmd(directed_rows[i]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == HOLD_AT_ITEM)
				hold_req = 1'b1;
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				calm = 1'b1;
			send_cmd(predicted(random_cmd()));
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (expected_writes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_writes.size() != 0) begin
			fails++;
			$display("%0d expected items never arrived", expected_writes.size());
		end

		$display("%0d input items: %0d sets (%0d unchanged), %0d bad indexes,",
			items_sent, n_set, n_unchanged, n_bad);
		$display("%0d flushed slots, %0d empty flushes, %0d failures",
			n_flush_slots, n_flush_empty, fails);
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
